>>> design/sorted_key_set_engine_core_macros.svh
// Assertion helpers for sorted_key_set_engine_core.sv.
`ifndef SORTED_KEY_SET_ENGINE_CORE_MACROS_SVH
`define SORTED_KEY_SET_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SKS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SKS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/sks_pkg.sv
package sks_pkg;

    localparam int KEY_W       = 16;
    localparam int OP_W        = 2;
    localparam int COUNT_OUT_W = 9;

    // Operation codes
    localparam logic [OP_W-1:0] OP_MEMBER = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic             cmp;   // latch compare flags against key
        logic             ins;   // open a slot and insert key
        logic             del;   // close the slot of the matching entry
        logic [KEY_W-1:0] key;
    } sks_cell_ctrl_t;

endpackage

>>> design/sks_if.sv
// Request channel: operation and key.
interface sks_req_if;
    import sks_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [KEY_W-1:0]  key;

    modport source (output valid, output op, output key, input ready);
    modport sink   (input valid, input op, input key, output ready);
endinterface

// Result channel: hit, full flag and count after the operation.
interface sks_res_if;
    import sks_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    hit;
    logic                    full_res;
    logic [COUNT_OUT_W-1:0]  stored_count;

    modport source (output valid, output hit, output full_res, output stored_count,
                    input ready);
    modport sink   (input valid, input hit, input full_res, input stored_count,
                    output ready);
endinterface

>>> design/sks_cell.sv
// One table slot: holds a key, compares it to the broadcast key and
// shifts toward either neighbor on insert or delete.
module sks_cell
    import sks_pkg::*;
#(
    parameter int CW  = 9,
    parameter int IDX = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  sks_cell_ctrl_t   ctrl,
    input  logic [CW-1:0]    count,
    input  logic             prev_lt,
    input  logic [KEY_W-1:0] prev_key,
    input  logic [KEY_W-1:0] next_key,
    output logic [KEY_W-1:0] key,
    output logic             lt,
    output logic             eq
);

    logic [KEY_W-1:0] key_reg;
    logic             lt_reg;
    logic             eq_reg;
    logic             occupied;

    assign occupied = (count > CW'(IDX));

    // Compare flags, taken in the cycle a request is accepted
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else if (ctrl.cmp)
        begin
            lt_reg <= occupied && (key_reg < ctrl.key);
            eq_reg <= occupied && (key_reg == ctrl.key);
        end
    end

    // Entries at or above the slot position move; lower ones hold
    always_ff @(posedge clk)
    begin
        if (ctrl.ins && !lt_reg)
        begin
            key_reg <= prev_lt ? ctrl.key : prev_key;
        end
        else if (ctrl.del && !lt_reg)
        begin
            key_reg <= next_key;
        end
    end

    assign key = key_reg;
    assign lt  = lt_reg;
    assign eq  = eq_reg;

endmodule

>>> design/sorted_key_set_engine_core.sv
// Sorted key set engine. Holds up to CAPACITY distinct 16-bit keys in
// ascending order in a row of cells, one key per cell. For each request
// (member, insert or delete), in the accept cycle every cell compares
// its key with the request key in parallel; then, in the update state,
// the sequencer resolves the hit and the row shifts one place right
// (insert) or left (delete) from the found position on. The result sits
// in an output register, so the next request is accepted as soon as the
// shift cycle has handed its result over; if the result register is still
// occupied the shift cycle waits for it. stored_count is the count taken
// modulo 512.
`include "sorted_key_set_engine_core_macros.svh"

module sorted_key_set_engine_core
    import sks_pkg::*;
#(
    parameter int CAPACITY = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    sks_req_if.sink     req,
    sks_res_if.source   res
);

    localparam int            CW    = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_UPD  = 1'b1;

    logic                   state_reg, state_next;
    logic [OP_W-1:0]        op_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [CW-1:0]          count_reg, count_next;
    logic                   res_valid_reg, res_valid_next;
    logic                   hit_reg, hit_next;
    logic                   full_reg, full_next;

    logic                   accept;
    logic                   commit;
    logic                   present;
    logic                   is_full;
    logic                   do_ins;
    logic                   do_del;
    logic [CW+COUNT_OUT_W-1:0] count_ext;
    sks_cell_ctrl_t         ctrl;

    logic [KEY_W-1:0]       cell_key [CAPACITY];
    logic [CAPACITY-1:0]    lt_vec;
    logic [CAPACITY-1:0]    eq_vec;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign commit    = (state_reg == S_UPD) && (!res_valid_reg || res.ready);

    // Keys are sorted, so at most one cell matches
    assign present = |eq_vec;
    assign is_full = (count_reg == CAP_C);

    // Decode the stored operation
    always_comb
    begin
        do_ins    = 1'b0;
        do_del    = 1'b0;
        hit_next  = 1'b0;
        full_next = 1'b0;
        unique case (op_reg)
            OP_MEMBER:
            begin
                hit_next = present;
            end
            OP_INSERT:
            begin
                do_ins    = !present && !is_full;
                hit_next  = do_ins;
                full_next = !present && is_full;
            end
            OP_DELETE:
            begin
                do_del   = present;
                hit_next = present;
            end
            default:
            begin
                hit_next = 1'b0;
            end
        endcase
    end

    // Broadcast to the cell row
    always_comb
    begin
        ctrl.cmp = accept;
        ctrl.ins = commit && do_ins;
        ctrl.del = commit && do_del;
        ctrl.key = accept ? req.key : key_reg;
    end

    // Sequencer and count
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        res_valid_next = res_valid_reg;
        if (res_valid_reg && res.ready)
        begin
            res_valid_next = 1'b0;
        end
        if (accept)
        begin
            state_next = S_UPD;
        end
        if (commit)
        begin
            state_next     = S_IDLE;
            res_valid_next = 1'b1;
            if (do_ins)
            begin
                count_next = count_reg + CW'(1);
            end
            else if (do_del)
            begin
                count_next = count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= req.op;
            key_reg <= req.key;
        end
        if (commit)
        begin
            hit_reg  <= hit_next;
            full_reg <= full_next;
        end
    end

    assign count_ext        = {{COUNT_OUT_W{1'b0}}, count_reg};
    assign res.valid        = res_valid_reg;
    assign res.hit          = hit_reg;
    assign res.full_res     = full_reg;
    assign res.stored_count = count_ext[COUNT_OUT_W-1:0];

    // Row of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic             prev_lt;
        logic [KEY_W-1:0] prev_key;
        logic [KEY_W-1:0] next_key;

        if (i == 0)
        begin : g_first
            assign prev_lt  = 1'b1;
            assign prev_key = key_reg;
        end
        else
        begin : g_mid
            assign prev_lt  = lt_vec[i-1];
            assign prev_key = cell_key[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_key = key_reg;
        end
        else
        begin : g_inner
            assign next_key = cell_key[i+1];
        end

        sks_cell #(
            .CW  (CW),
            .IDX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .count    (count_reg),
            .prev_lt  (prev_lt),
            .prev_key (prev_key),
            .next_key (next_key),
            .key      (cell_key[i]),
            .lt       (lt_vec[i]),
            .eq       (eq_vec[i])
        );
    end

    // Checks
    `SKS_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_reg <= CAP_C, "count above capacity")
    `SKS_ASSERT_IMPLY(a_no_ins_del, clk, rst_n, 1'b1, !(ctrl.ins && ctrl.del), "insert and delete together")
    `SKS_ASSERT_NEXT(a_count_hold, clk, rst_n, !commit, count_reg == $past(count_reg), "count moved outside commit")
    `SKS_ASSERT_NEXT(a_ins_grow, clk, rst_n, ctrl.ins, count_reg == $past(count_reg) + CW'(1), "insert did not grow count")
    `SKS_ASSERT_IMPLY(a_full_excl, clk, rst_n, res_valid_reg && full_reg, !hit_reg, "full refusal reported as hit")

endmodule

>>> verif/tb_sorted_key_set_engine_core.sv
module tb_sorted_key_set_engine_core;
    timeunit 1ns;
    timeprecision 1ps;
    import sks_pkg::*;

    localparam int CAP            = 256;
    localparam int MAX_WAIT       = 18;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_PRINTED    = 100;
    localparam int N_DIRECTED     = 25;

    // op code 3 has no meaning in the block; it must act as a no-op
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic                   hit;
        logic                   full_res;
        logic [COUNT_OUT_W-1:0] count;
    } set_result_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic             pinned;   // expected result typed in below
        set_result_t      outcome;
    } directed_row_t;

    logic clk;
    logic rst_n;

    sks_req_if req_ch ();
    sks_res_if res_ch ();

    sorted_key_set_engine_core #(
        .CAPACITY (CAP)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    // Shadow copy of the key table
    logic [KEY_W-1:0] held_keys [CAP];
    int               held_count;

    set_result_t expected_results [$];

    int mismatches;
    int results_seen;
    int requests_sent;
    int op_counts [4];
    int hit_total;
    int full_refusals;
    int peak_count;
    int ready_wait;
    bit send_quiet;
    bit recv_quiet;

    // Directed rows: empty table, both key extremes, duplicates,
    // head/middle/tail removal, absent delete, unused op code
    directed_row_t directed_rows [N_DIRECTED] = '{
        '{OP_MEMBER, 16'h0000, 1'b1, '{1'b0, 1'b0, 9'd0}},
        '{OP_DELETE, 16'h0000, 1'b1, '{1'b0, 1'b0, 9'd0}},
        '{OP_UNUSED, 16'hFFFF, 1'b1, '{1'b0, 1'b0, 9'd0}},
        '{OP_INSERT, 16'h0000, 1'b1, '{1'b1, 1'b0, 9'd1}},
        '{OP_INSERT, 16'hFFFF, 1'b1, '{1'b1, 1'b0, 9'd2}},
        '{OP_INSERT, 16'h0000, 1'b1, '{1'b0, 1'b0, 9'd2}},
        '{OP_MEMBER, 16'h0000, 1'b1, '{1'b1, 1'b0, 9'd2}},
        '{OP_MEMBER, 16'hFFFF, 1'b1, '{1'b1, 1'b0, 9'd2}},
        '{OP_MEMBER, 16'h8000, 1'b1, '{1'b0, 1'b0, 9'd2}},
        '{OP_INSERT, 16'h8000, 1'b0, '{1'b0, 1'b0, 9'd0}},
        '{OP_INSERT, 16'h7FFF, 1'b0, '{1'b0, 1'b0, 9'd0}},
        '{OP_INSERT, 16'h0001, 1'b0, '{1'b0, 1'b0, 9'd0}},
        '{OP_INSERT, 16'hFFFE, 1'b0, '{1'b0, 1'b0, 9'd0}},
        '{OP_UNUSED, 16'h8000, 1'b0, '{1'b0, 1'b0, 9'd0}},
        '{OP_MEMBER, 16'h7FFF, 1'b0, '{1'b0, 1'b0, 9'd0}},
        '{OP_DELETE, 16'h8000, 1'b0, '{1'b0, 1'b0, 9'd0}},
        '{OP_DELETE, 16'h0000, 1'b0, '{1'b0, 1'b0, 9'd0}},
        '{OP_DELETE, 16'hFFFF, 1'b0, '{1'b0, 1'b0, 9'd0}},
        '{OP_DELETE, 16'hFFFF, 1'b0, '{1'b0, 1'b0, 9'd0}},
        '{OP_INSERT, 16'h5555, 1'b0, '{1'b0, 1'b0, 9'd0}},
        '{OP_INSERT, 16'hAAAA, 1'b0, '{1'b0, 1'b0, 9'd0}},
        '{OP_MEMBER, 16'hAAAA, 1'b0, '{1'b0, 1'b0, 9'd0}},
        '{OP_DELETE, 16'h0001, 1'b0, '{1'b0, 1'b0, 9'd0}},
        '{OP_MEMBER, 16'h0001, 1'b0, '{1'b0, 1'b0, 9'd0}},
        '{OP_INSERT, 16'h0000, 1'b0, '{1'b0, 1'b0, 9'd0}}
    };

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one operation to the shadow table, return what the block must answer
    function automatic set_result_t apply_set_op(input logic [OP_W-1:0] op,
                                                 input logic [KEY_W-1:0] key);
        set_result_t outcome;
        int          pos;
        bit          present;
        outcome = '0;
        pos = 0;
        while (pos < held_count && held_keys[pos] < key)
            pos++;
        present = (pos < held_count) && (held_keys[pos] == key);
        case (op)
            OP_MEMBER:
                outcome.hit = present;
            OP_INSERT:
                if (!present)
                begin
                    if (held_count >= CAP)
                        outcome.full_res = 1'b1;
                    else
                    begin
                        for (int i = held_count; i > pos; i--)
                            held_keys[i] = held_keys[i-1];
                        held_keys[pos] = key;
                        held_count++;
                        outcome.hit = 1'b1;
                    end
                end
            OP_DELETE:
                if (present)
                begin
                    for (int i = pos; i + 1 < held_count; i++)
                        held_keys[i] = held_keys[i+1];
                    held_count--;
                    outcome.hit = 1'b1;
                end
            default: ;
        endcase
        outcome.count = held_count[COUNT_OUT_W-1:0];
        return outcome;
    endfunction

    function automatic logic [OP_W-1:0] pick_op(input int w_member, input int w_insert,
                                                input int w_delete, input int w_unused);
        int r;
        r = $urandom_range(0, w_member + w_insert + w_delete + w_unused - 1);
        if (r < w_member)
            return OP_MEMBER;
        if (r < w_member + w_insert)
            return OP_INSERT;
        if (r < w_member + w_insert + w_delete)
            return OP_DELETE;
        return OP_UNUSED;
    endfunction

    // Either a key currently held (chance in percent) or any 16-bit key
    function automatic logic [KEY_W-1:0] pick_key(input int held_pct);
        if (held_count > 0 && $urandom_range(0, 99) < held_pct)
            return held_keys[$urandom_range(0, held_count - 1)];
        return KEY_W'($urandom);
    endfunction

    // Small pool at both ends of the key range, for dense collisions
    function automatic logic [KEY_W-1:0] pool_key();
        if ($urandom_range(0, 1) == 0)
            return KEY_W'($urandom_range(0, 15));
        return 16'hFFF0 + KEY_W'($urandom_range(0, 15));
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Drive one request, wait for it to be taken, record its expectation
    task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                                input logic pinned, input set_result_t pinned_res);
        int          gap;
        set_result_t predicted;
        gap = send_quiet ? 0 : $urandom_range(0, MAX_WAIT);
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.key   <= key;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = apply_set_op(op, key);
        expected_results.push_back(pinned ? pinned_res : predicted);
        op_counts[op]++;
        hit_total     += predicted.hit;
        full_refusals += predicted.full_res;
        if (held_count > peak_count)
            peak_count = held_count;
        requests_sent++;
        if (requests_sent % 32 == 0)
            send_quiet = ($urandom_range(0, 3) == 0);
    endtask

    // Result check at the rising edge
    always @(posedge clk)
    begin : result_check
        set_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("result %0d arrived with no request pending",
                                          results_seen));
            else
            begin
                want = expected_results.pop_front();
                if (res_ch.hit !== want.hit)
                    report_mismatch($sformatf("result %0d hit %b, expected %b",
                                              results_seen, res_ch.hit, want.hit));
                if (res_ch.full_res !== want.full_res)
                    report_mismatch($sformatf("result %0d full_res %b, expected %b",
                                              results_seen, res_ch.full_res,
                                              want.full_res));
                if (res_ch.stored_count !== want.count)
                    report_mismatch($sformatf("result %0d stored_count %0d, expected %0d",
                                              results_seen, res_ch.stored_count,
                                              want.count));
            end
            results_seen++;
            if (results_seen % 32 == 0)
                recv_quiet = ($urandom_range(0, 3) == 0);
            ready_wait = recv_quiet ? 0 : $urandom_range(0, MAX_WAIT);
        end
    end

    // Result-side backpressure, changed at the falling edge
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
                res_ch.ready <= 1'b0;
            else if (ready_wait > 0)
            begin
                res_ch.ready <= 1'b0;
                ready_wait--;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // Watchdog: too long without any handshake on either channel
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[%0t] no request or result moved for %0d cycles", $realtime,
                 WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // Main stimulus
    initial
    begin : stimulus
        int               steps;
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;

        rst_n         = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.op     = OP_MEMBER;
        req_ch.key    = '0;
        held_count    = 0;
        mismatches    = 0;
        results_seen  = 0;
        requests_sent = 0;
        hit_total     = 0;
        full_refusals = 0;
        peak_count    = 0;
        ready_wait    = 0;
        send_quiet    = 1'b0;
        recv_quiet    = 1'b0;
        foreach (op_counts[i])
            op_counts[i] = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table
        foreach (directed_rows[i])
            send_request(directed_rows[i].op, directed_rows[i].key,
                         directed_rows[i].pinned, directed_rows[i].outcome);

        // Fill the table up to capacity, mostly fresh keys
        steps = 0;
        while (held_count < CAP && steps < 1500)
        begin
            op  = pick_op(8, 85, 4, 3);
            key = pick_key(op == OP_INSERT ? 5 : 50);
            send_request(op, key, 1'b0, '0);
            steps++;
        end

        // Work around the full table: refused inserts, duplicates, refills
        repeat (30)
        begin
            op  = pick_op(15, 65, 15, 5);
            key = pick_key(op == OP_INSERT ? 35 : 60);
            send_request(op, key, 1'b0, '0);
        end

        // Drain back to empty, mostly deletes of held keys
        steps = 0;
        while (held_count > 0 && steps < 3000)
        begin
            op  = pick_op(9, 8, 80, 3);
            key = (op == OP_DELETE) ? pick_key(93) : pick_key(40);
            send_request(op, key, 1'b0, '0);
            steps++;
        end

        // Dense mix over a small key pool at both ends of the range
        repeat (140)
        begin
            op = pick_op(30, 35, 30, 5);
            send_request(op, pool_key(), 1'b0, '0);
        end

        @(negedge clk);
        req_ch.valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

        $display("Sent %0d requests: %0d member, %0d insert, %0d delete, %0d unused code",
                 requests_sent, op_counts[OP_MEMBER], op_counts[OP_INSERT],
                 op_counts[OP_DELETE], op_counts[OP_UNUSED]);
        $display("Checked %0d results: %0d hits, %0d inserts refused when full, peak %0d/%0d",
                 results_seen, hit_total, full_refusals, peak_count, CAP);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
